// File: design/assert_macros.svh
// assertion macros used by the timer queue sequencer (dltq_ctrl)
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define DLTQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DLTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dltq_pkg.sv
// types and constants for the delta list timer queue
// used by dltq_cell, dltq_ctrl and delta_list_timer_queue; no dependencies
package dltq_pkg;

    localparam int DELTA_W  = 32;
    localparam int ID_W     = 5;
    localparam int MIN_W    = 16;
    localparam int STATUS_W = 3;
    localparam int MAX_RUN  = 32;
    localparam int RUN_W    = $clog2(MAX_RUN);

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FIRED     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_IDLE_TICK = 3'd4;

    localparam logic [MIN_W-1:0] MIN_TICKS_RESET = 16'd1;

    // command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_WALK,
        CMD_INSERT,
        CMD_SHIFT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        logic [MIN_W-1:0] min_ticks;
        logic [ID_W-1:0]  new_id;
    } cell_bcast_t;

    // per-cell position flags
    typedef struct packed {
        logic sel;
        logic after;
        logic occupied;
        logic first;
    } cell_sel_t;

    // what a cell hands to its neighbors
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [ID_W-1:0]    id;
        logic [DELTA_W-1:0] rem;
        logic               here;
    } cell_link_t;

endpackage

// File: design/dltq_cell.sv
// one cell of the delta list: holds one entry and the walking insert remainder
// depends on dltq_pkg
module dltq_cell
    import dltq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_bcast_t bcast,
    input  cell_sel_t   pos_flags,
    input  cell_link_t  left,
    input  cell_link_t  right,
    output cell_link_t  link,
    output logic        stop
);

    logic [DELTA_W-1:0] delta_reg, delta_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [DELTA_W-1:0] rem_reg, rem_next;
    logic               here_reg, here_next;
    logic [DELTA_W-1:0] min_ext;
    logic [DELTA_W-1:0] ins_delta;
    logic               fits;

    assign min_ext = DELTA_W'(bcast.min_ticks);

    // insert point: head uses a strict compare, later cells stop on equal
    assign fits = pos_flags.first ? (left.rem < delta_reg) : (left.rem <= delta_reg);
    assign stop = pos_flags.sel && (bcast.cmd == CMD_WALK) && (!pos_flags.occupied || fits);

    // short deltas chain onto the predecessor, except into an empty queue
    assign ins_delta = (pos_flags.first && !pos_flags.occupied) ? left.rem :
                       ((left.rem < min_ext) ? '0 : left.rem);

    // next entry and remainder
    always_comb
    begin
        delta_next = delta_reg;
        id_next    = id_reg;
        rem_next   = rem_reg;
        here_next  = 1'b0;
        unique case (bcast.cmd)
            CMD_WALK:
            begin
                if (pos_flags.sel)
                begin
                    here_next = stop;
                    rem_next  = stop ? ins_delta : (left.rem - delta_reg);
                end
            end
            CMD_INSERT:
            begin
                if (here_reg)
                begin
                    delta_next = rem_reg;
                    id_next    = bcast.new_id;
                end
                else if (left.here)
                begin
                    delta_next = left.delta - left.rem;
                    id_next    = left.id;
                end
                else if (pos_flags.after)
                begin
                    delta_next = left.delta;
                    id_next    = left.id;
                end
            end
            CMD_SHIFT:
            begin
                delta_next = right.delta;
                id_next    = right.id;
            end
            default:
            begin
            end
        endcase
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        id_reg    <= id_next;
        rem_reg   <= rem_next;
    end

    // insert marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            here_reg <= 1'b0;
        else
            here_reg <= here_next;
    end

    assign link.delta = delta_reg;
    assign link.id    = id_reg;
    assign link.rem   = rem_reg;
    assign link.here  = here_reg;

endmodule

// File: design/dltq_ctrl.sv
// sequencer of the timer queue: handshakes, timer state, walk and fire runs
// depends on dltq_pkg and assert_macros.svh
`include "assert_macros.svh"

module dltq_ctrl
    import dltq_pkg::*;
#(
    parameter int EVENTS = 32,
    parameter int CNT_W  = $clog2(EVENTS + 1),
    parameter int POS_W  = $clog2(EVENTS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [DELTA_W-1:0]  ticks,
    input  logic [ID_W-1:0]     event_id,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MIN_W-1:0]    cfg_data,
    output logic                result_strobe,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     fired_id,
    output logic                last,
    output cell_bcast_t         bcast,
    output logic [POS_W-1:0]    pos,
    output logic [CNT_W-1:0]    count,
    output logic [DELTA_W-1:0]  walk_rem,
    input  logic                stop,
    input  logic [ID_W-1:0]     head_id,
    input  logic [DELTA_W-1:0]  next_delta
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_INSERT = 4'b0100,
        S_FIRE   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [DELTA_W-1:0]    t_reg, t_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DELTA_W-1:0]    countdown_reg, countdown_next;
    logic [DELTA_W-1:0]    elapsed_reg, elapsed_next;
    logic                  armed_reg, armed_next;
    logic [MIN_W-1:0]      min_reg, min_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic                  strobe_reg, strobe_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ID_W-1:0]       fired_reg, fired_next;
    logic                  last_reg, last_next;
    logic                  accept;
    logic                  run_more;
    cell_cmd_t             cmd;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = start && (state_reg == S_IDLE);

    // run continues while more entries remain, the run limit is not reached and the next entry has a zero delta
    assign run_more = (count_reg > CNT_W'(1)) && (run_reg != RUN_W'(MAX_RUN - 1))
                      && (next_delta == '0);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        id_next        = id_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        countdown_next = countdown_reg;
        elapsed_next   = elapsed_reg;
        armed_next     = armed_reg;
        min_next       = min_reg;
        run_next       = run_reg;
        strobe_next    = 1'b0;
        status_next    = status_reg;
        fired_next     = fired_reg;
        last_next      = last_reg;
        cmd            = CMD_HOLD;

        if (cfg_valid && cfg_ready)
            min_next = cfg_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!op)
                    begin
                        if (ticks == '0)
                        begin
                            strobe_next = 1'b1;
                            status_next = STAT_ZERO;
                            fired_next  = '0;
                            last_next   = 1'b1;
                        end
                        else if (count_reg == CNT_W'(EVENTS))
                        begin
                            strobe_next = 1'b1;
                            status_next = STAT_FULL;
                            fired_next  = '0;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            t_next     = (ticks > elapsed_reg) ? (ticks - elapsed_reg) : '0;
                            id_next    = event_id;
                            pos_next   = '0;
                            state_next = S_WALK;
                        end
                    end
                    else if (!armed_reg || (countdown_reg > DELTA_W'(1)))
                    begin
                        if (armed_reg)
                        begin
                            countdown_next = countdown_reg - 1'b1;
                            if (elapsed_reg != '1)
                                elapsed_next = elapsed_reg + 1'b1;
                        end
                        strobe_next = 1'b1;
                        status_next = STAT_IDLE_TICK;
                        fired_next  = '0;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        armed_next     = 1'b0;
                        countdown_next = '0;
                        elapsed_next   = '0;
                        if (count_reg == '0)
                        begin
                            strobe_next = 1'b1;
                            status_next = STAT_IDLE_TICK;
                            fired_next  = '0;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            run_next   = '0;
                            state_next = S_FIRE;
                        end
                    end
                end
            end
            S_WALK:
            begin
                cmd = CMD_WALK;
                if (stop)
                    state_next = S_INSERT;
                else
                    pos_next = pos_reg + 1'b1;
            end
            S_INSERT:
            begin
                cmd         = CMD_INSERT;
                count_next  = count_reg + 1'b1;
                strobe_next = 1'b1;
                status_next = STAT_OK;
                fired_next  = '0;
                last_next   = 1'b1;
                // empty queue arms if idle; a new head always re-arms
                if ((count_reg == '0) ? !armed_reg : (pos_reg == '0))
                begin
                    countdown_next = t_reg;
                    elapsed_next   = '0;
                    armed_next     = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_FIRE:
            begin
                cmd         = CMD_SHIFT;
                count_next  = count_reg - 1'b1;
                run_next    = run_reg + 1'b1;
                strobe_next = 1'b1;
                status_next = STAT_FIRED;
                fired_next  = head_id;
                last_next   = !run_more;
                if (!run_more)
                begin
                    if (count_reg > CNT_W'(1))
                    begin
                        countdown_next = next_delta;
                        elapsed_next   = '0;
                        armed_next     = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            countdown_reg <= '0;
            elapsed_reg   <= '0;
            armed_reg     <= 1'b0;
            min_reg       <= MIN_TICKS_RESET;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            countdown_reg <= countdown_next;
            elapsed_reg   <= elapsed_next;
            armed_reg     <= armed_next;
            min_reg       <= min_next;
            strobe_reg    <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        id_reg     <= id_next;
        pos_reg    <= pos_next;
        run_reg    <= run_next;
        status_reg <= status_next;
        fired_reg  <= fired_next;
        last_reg   <= last_next;
    end

    assign bcast.cmd       = cmd;
    assign bcast.min_ticks = min_reg;
    assign bcast.new_id    = id_reg;
    assign pos             = pos_reg;
    assign count           = count_reg;
    assign walk_rem        = t_reg;
    assign result_strobe   = strobe_reg;
    assign status          = status_reg;
    assign fired_id        = fired_reg;
    assign last            = last_reg;

    // checks
    `DLTQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(EVENTS), "entry count above capacity")
    `DLTQ_ASSERT_ALWAYS(a_armed_nonempty, !armed_reg || (count_reg != '0), "timer armed on empty queue")
    `DLTQ_ASSERT_ALWAYS(a_walk_in_list, (state_reg != S_WALK) || (CNT_W'(pos_reg) <= count_reg), "walk passed the tail")
    `DLTQ_ASSERT_NEXT(a_insert_grows, state_reg == S_INSERT, count_reg == $past(count_reg) + 1'b1, "insert did not add an entry")

endmodule

// File: design/delta_list_timer_queue.sv
// top level of the delta list timer queue: sequencer plus a chain of entry cells
// depends on dltq_pkg, dltq_cell and dltq_ctrl
//
// usage
//   input: drive op, ticks, event_id with start; an item transfers on a clock
//   edge with start high and busy low. op 0 schedules an event, op 1 is one tick.
//   config: min_ticks is written on cfg_data when cfg_valid and cfg_ready are high;
//   cfg_ready is high whenever the block is idle.
//   results: status, fired_id and last are valid for the single cycle that
//   result_strobe is high; every result must be taken then, there is no stall.
// per operation
//   reject and plain tick: one result, strobed the cycle after the transfer,
//   busy stays low so the next item may follow at once.
//   schedule at list position p: the insert walk moves one cell per cycle, then the
//   insert state writes the entry and registers the result; busy is high through both.
//   expiring tick firing n events: n results on consecutive cycles, one registered
//   from each fire state; busy is high in those states while the chain shifts left.
// reset: the list is empty, the timer is disarmed and min_ticks is 1.
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int EVENTS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [DELTA_W-1:0]  ticks,
    input  logic [ID_W-1:0]     event_id,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MIN_W-1:0]    cfg_data,
    output logic                result_strobe,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     fired_id,
    output logic                last
);

    localparam int CNT_W = $clog2(EVENTS + 1);
    localparam int POS_W = $clog2(EVENTS);

    cell_bcast_t        bcast;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
    logic [DELTA_W-1:0] walk_rem;
    cell_link_t         head_link;
    cell_link_t         links     [EVENTS];
    cell_sel_t          pos_flags [EVENTS];
    logic [EVENTS-1:0]  stops;

    // sequencer
    dltq_ctrl #(
        .EVENTS (EVENTS),
        .CNT_W  (CNT_W),
        .POS_W  (POS_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .ticks         (ticks),
        .event_id      (event_id),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .status        (status),
        .fired_id      (fired_id),
        .last          (last),
        .bcast         (bcast),
        .pos           (pos),
        .count         (count),
        .walk_rem      (walk_rem),
        .stop          (|stops),
        .head_id       (links[0].id),
        .next_delta    (links[1].delta)
    );

    // the walk remainder enters the chain at the head
    assign head_link.delta = '0;
    assign head_link.id    = '0;
    assign head_link.rem   = walk_rem;
    assign head_link.here  = 1'b0;

    // cell chain
    for (genvar g = 0; g < EVENTS; g++)
    begin : g_cell
        cell_link_t left_in;
        cell_link_t right_in;

        assign pos_flags[g].sel      = (pos == POS_W'(g));
        assign pos_flags[g].after    = (pos < POS_W'(g));
        assign pos_flags[g].occupied = (CNT_W'(g) < count);
        assign pos_flags[g].first    = 1'(g == 0);

        if (g == 0)
        begin : g_left_head
            assign left_in = head_link;
        end
        else
        begin : g_left_cell
            assign left_in = links[g-1];
        end

        if (g == EVENTS - 1)
        begin : g_right_tail
            assign right_in = links[g];
        end
        else
        begin : g_right_cell
            assign right_in = links[g+1];
        end

        dltq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bcast     (bcast),
            .pos_flags (pos_flags[g]),
            .left      (left_in),
            .right     (right_in),
            .link      (links[g]),
            .stop      (stops[g])
        );
    end

endmodule
